>>> rtl/plir_pkg.sv
// Package for the piecewise linear interpolation table.
// Holds the word types, operation and region codes, the config address and controller states.
// No dependencies.
package plir_pkg;

    typedef struct packed {
        logic               operation;
        logic [5:0]         point_index;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] query_x;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] value_y;
        logic [5:0]         segment;
        logic [1:0]         region;
        logic               saturated;
        logic               zero_span;
    } t_out_word;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] REGION_INTERIOR = 2'd0;
    localparam logic [1:0] REGION_EXACT    = 2'd1;
    localparam logic [1:0] REGION_BELOW    = 2'd2;
    localparam logic [1:0] REGION_ABOVE    = 2'd3;

    localparam logic [2:0] ADDR_POINTS_IN_USE = 3'd0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIRST,
        S_LAST,
        S_CHK,
        S_SCAN,
        S_DRAIN,
        S_SDEC,
        S_SEGA,
        S_SEGB,
        S_DIFF,
        S_DIV,
        S_MUL,
        S_ADD,
        S_SUM,
        S_OUT
    } t_state;

endpackage

>>> rtl/plir_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module plir_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/piecewise_linear_interp.sv
// Piecewise linear interpolation table: top level.
// Depends on plir_pkg and plir_ram.
//
// Breakpoints (x, y) in signed Q format live in one RAM, written by write words.
// A query word reads the first and last breakpoints; when x lies strictly between them it
// scans points_in_use slots (clamped to 2..POINTS) through the RAM read port, one slot per
// cycle, and decodes the scan. An exact hit returns the stored y. Otherwise a segment
// evaluation reads the chosen segment and, unless its x span is zero, runs a restoring
// divider for the slope, one bit per cycle, followed by a split multiply and a saturating
// add. One word is in work at a time; the result is held until taken.
// points_in_use is written through the APB port at address 0.
module piecewise_linear_interp #(
    parameter int POINTS    = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  plir_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output plir_pkg::t_out_word o_out_word,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import plir_pkg::*;

    localparam int AW  = $clog2(POINTS);
    localparam int NW  = 33 + FRAC_BITS;
    localparam int DCW = $clog2(NW);

    t_state r_state, n_state;

    logic [6:0]           r_piu;
    logic [AW-1:0]        r_last, w_last;
    logic signed [31:0]   r_q, r_x0, r_xa, r_ya, r_yhit;
    logic [AW-1:0]        r_cnt, r_pidx, r_seg, r_hidx;
    logic                 r_pend, r_hit;
    logic [1:0]           r_region;
    logic [32:0]          r_mdx, r_md;
    logic [32:0]          r_rem;
    logic [NW-1:0]        r_num, r_quo;
    logic [DCW-1:0]       r_dcnt;
    logic                 r_pneg;
    logic [64:0]          r_plo, r_phi;
    logic [96:0]          r_prod;
    t_out_word            r_res;

    logic                 w_in_acc, w_wr, w_we;
    logic [AW-1:0]        w_raddr;
    logic [63:0]          w_rdata;
    logic signed [31:0]   w_rx, w_ry;
    logic signed [32:0]   w_dx, w_dy, w_d;
    logic [33:0]          w_trial;
    logic [63:0]          w_slope;
    logic [96:0]          w_prod;
    logic [39:0]          w_mag;
    logic                 w_big;
    logic signed [41:0]   w_sum;

    assign w_in_acc = i_in_valid && !o_in_stall;
    assign w_wr     = w_in_acc && (i_in_word.operation == OP_WRITE);
    assign w_we     = w_wr && (32'(i_in_word.point_index) < POINTS);

    plir_ram #(.WIDTH(64), .DEPTH(POINTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (AW'(i_in_word.point_index)),
        .i_wdata ({i_in_word.point_x, i_in_word.point_y}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rx = w_rdata[63:32];
    assign w_ry = w_rdata[31:0];

    // config port
    assign pready = 1'b1;
    assign prdata = {25'b0, r_piu};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_piu <= 7'd2;
        end else if (psel && penable && pwrite && paddr == ADDR_POINTS_IN_USE) begin
            r_piu <= pwdata[6:0];
        end
    end

    always_comb begin
        if (r_piu < 7'd2) begin
            w_last = AW'(1);
        end else if (32'(r_piu) > POINTS) begin
            w_last = AW'(POINTS - 1);
        end else begin
            w_last = AW'(r_piu - 7'd1);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc && i_in_word.operation == OP_QUERY) begin
                    n_state = S_FIRST;
                end
            end
            S_FIRST: n_state = S_LAST;
            S_LAST:  n_state = S_CHK;
            S_CHK: begin
                if (r_q <= r_x0 || r_q >= w_rx) begin
                    n_state = S_SEGA;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_cnt == r_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_SDEC;
            S_SDEC:  n_state = r_hit ? S_OUT : S_SEGA;
            S_SEGA:  n_state = S_SEGB;
            S_SEGB:  n_state = S_DIFF;
            S_DIFF:  n_state = (w_dx == 33'sd0) ? S_OUT : S_DIV;
            S_DIV: begin
                if (r_dcnt == DCW'(NW - 1)) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: n_state = S_ADD;
            S_ADD: n_state = S_SUM;
            S_SUM: n_state = S_OUT;
            S_OUT: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_stall  = (r_state != S_IDLE);
        o_out_valid = (r_state == S_OUT);
        case (r_state)
            S_LAST: w_raddr = r_last;
            S_SCAN: w_raddr = r_cnt;
            S_SEGA: w_raddr = r_seg;
            S_SEGB: w_raddr = r_seg + AW'(1);
            default: w_raddr = '0;
        endcase
    end

    assign o_out_word = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath
    assign w_dx    = 33'(w_rx) - 33'(r_xa);
    assign w_dy    = 33'(w_ry) - 33'(r_ya);
    assign w_d     = 33'(r_q) - 33'(r_xa);
    assign w_trial = {r_rem, r_num[NW-1]};
    assign w_slope = 64'(r_quo);
    assign w_prod  = {r_phi, 32'b0} + 97'(r_plo);
    assign w_big   = |(r_prod >> (FRAC_BITS + 40));
    assign w_mag   = 40'(r_prod >> FRAC_BITS);
    assign w_sum   = 42'(r_ya) + (r_pneg ? -$signed({2'b0, w_mag}) : $signed({2'b0, w_mag}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_hit  <= 1'b0;
        end else begin
            r_pend <= (r_state == S_SCAN);
            r_pidx <= r_cnt;
            if (r_pend) begin
                if (w_rx == r_q && !r_hit) begin
                    r_hit  <= 1'b1;
                    r_hidx <= r_pidx;
                    r_yhit <= w_ry;
                end
                if (r_pidx != r_last && w_rx < r_q) begin
                    r_seg <= r_pidx;
                end
            end
            case (r_state)
                S_IDLE: begin
                    r_q    <= i_in_word.query_x;
                    r_last <= w_last;
                end
                S_LAST: r_x0 <= w_rx;
                S_CHK: begin
                    r_cnt <= '0;
                    r_hit <= 1'b0;
                    if (r_q <= r_x0) begin
                        r_seg    <= '0;
                        r_region <= REGION_BELOW;
                    end else if (r_q >= w_rx) begin
                        r_seg    <= r_last - AW'(1);
                        r_region <= REGION_ABOVE;
                    end else begin
                        r_seg    <= '0;
                        r_region <= REGION_INTERIOR;
                    end
                end
                S_SCAN: r_cnt <= r_cnt + AW'(1);
                S_SDEC: begin
                    r_res.value_y   <= r_yhit;
                    r_res.segment   <= 6'(r_hidx);
                    r_res.region    <= REGION_EXACT;
                    r_res.saturated <= 1'b0;
                    r_res.zero_span <= 1'b0;
                end
                S_SEGB: begin
                    r_xa <= w_rx;
                    r_ya <= w_ry;
                end
                S_DIFF: begin
                    r_mdx  <= w_dx[32] ? 33'(-w_dx) : 33'(w_dx);
                    r_md   <= w_d[32] ? 33'(-w_d) : 33'(w_d);
                    r_num  <= NW'(w_dy[32] ? 33'(-w_dy) : 33'(w_dy)) << FRAC_BITS;
                    r_rem  <= '0;
                    r_dcnt <= '0;
                    r_pneg <= w_dy[32] ^ w_dx[32] ^ w_d[32];
                    r_res.value_y   <= '0;
                    r_res.segment   <= 6'(r_seg);
                    r_res.region    <= r_region;
                    r_res.saturated <= 1'b0;
                    r_res.zero_span <= (w_dx == 33'sd0);
                end
                S_DIV: begin
                    r_dcnt <= r_dcnt + DCW'(1);
                    r_num  <= r_num << 1;
                    if (w_trial >= {1'b0, r_mdx}) begin
                        r_rem <= 33'(w_trial - {1'b0, r_mdx});
                        r_quo <= {r_quo[NW-2:0], 1'b1};
                    end else begin
                        r_rem <= w_trial[32:0];
                        r_quo <= {r_quo[NW-2:0], 1'b0};
                    end
                end
                S_MUL: begin
                    r_plo <= 65'(w_slope[31:0]) * 65'(r_md);
                    r_phi <= 65'(w_slope[63:32]) * 65'(r_md);
                end
                S_ADD: r_prod <= w_prod;
                S_SUM: begin
                    if (w_big) begin
                        r_res.saturated <= 1'b1;
                        r_res.value_y   <= r_pneg ? 32'sh80000000 : 32'sh7FFFFFFF;
                    end else if (w_sum[41:31] != {11{w_sum[41]}}) begin
                        r_res.saturated <= 1'b1;
                        r_res.value_y   <= w_sum[41] ? 32'sh80000000 : 32'sh7FFFFFFF;
                    end else begin
                        r_res.value_y   <= w_sum[31:0];
                    end
                end
                default: ;
            endcase
        end
    end

    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("result pending while input open");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_word.operation == OP_QUERY) |=> o_in_stall)
        else $error("query not taken into work");

    a_zero_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.zero_span) |->
            (o_out_word.value_y == 32'sd0 && !o_out_word.saturated))
        else $error("zero span with nonzero value or saturation");

    a_exact_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.region == REGION_EXACT) |->
            (!o_out_word.saturated && !o_out_word.zero_span))
        else $error("exact hit with flags set");

endmodule
